FILE: src/bcpm_pkg.sv
// shared types and constants of the bit-plane context probability model
package bcpm_pkg;

	localparam int VAL_W  = 16;
	localparam int PROB_W = 16;
	localparam int NBR    = 9;
	localparam int DEPTH_W = 5;
	localparam int MAXV_W = 17;

	localparam logic [PROB_W-1:0] PROB_INIT = 16'h8000;
	localparam logic [PROB_W-1:0] PROB_MAX  = 16'hFFFF;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = 5'd16;

	// command codes carried in tuser
	localparam logic CMD_CODE  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// neighbour positions, also the bit order of in_bounds
	localparam int NB_NW = 0;
	localparam int NB_N  = 1;
	localparam int NB_NE = 2;
	localparam int NB_W  = 3;
	localparam int NB_C  = 4;
	localparam int NB_E  = 5;
	localparam int NB_SW = 6;
	localparam int NB_S  = 7;
	localparam int NB_SE = 8;

	typedef logic [NBR-1:0][VAL_W-1:0] sample_arr_t;

endpackage

FILE: src/bitplane_context_probability_model_top.sv
// top level: stream ports, probability table memory and its read-modify-write pipeline
// a code transaction passes the predict registers, the table read and the output register
// throughput: one transaction per cycle unless m_tready stalls; write forwarding covers
// back-to-back cell hits; a clear holds s_tready low through the pipeline, then the sweep
// reset: arst_n async active low clears control state, then a sweep writes every table cell

module bitplane_context_probability_model_top #(
	parameter int TABLE_ENTRIES = 65536,
	parameter int SAMPLE_BITS   = 16
) (
	input  logic         clk,
	input  logic         arst_n,

	// input stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// plane[3:0], in_bounds[12:4], value_nw[28:13], value_n[44:29], value_ne[60:45],
	// value_w[76:61], value_centre[92:77], value_e[108:93], value_sw[124:109],
	// value_s[140:125], value_se[156:141], zero fill[159:157]
	input  logic [159:0] s_tdata,
	// command[0]
	input  logic         s_tuser,

	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// coded_bit[0], prob_zero[16:1], context_res[32:17], zero fill[39:33]
	output logic [39:0]  m_tdata,

	// channel_depth register write
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [4:0]   cfg_data
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int PW    = bcpm_pkg::PROB_W;
	localparam int MW    = bcpm_pkg::MAXV_W;
	localparam logic [MW-1:0] TMAX     = MW'(TABLE_ENTRIES - 1);
	localparam logic [MW-1:0] MAXV_RST = (TMAX < MW'(255)) ? TMAX : MW'(255);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	// unpacked input fields
	logic [3:0]                  in_plane;
	logic [bcpm_pkg::NBR-1:0]    in_flags;
	bcpm_pkg::sample_arr_t       in_vals;
	logic                        in_bit;

	// handshake and pipeline control
	logic s_accept;
	logic adv;
	logic pipe_we;
	logic busy_q;
	logic sweeping_q;
	logic [IDX_W-1:0] sweep_cnt_q;

	logic vld_s1, vld_s2, vld_s3;
	logic cmd_s1, cmd_s2, cmd_s3;
	logic bit_s1, bit_s2, bit_s3;
	logic [3:0] plane_s1, plane_s2, plane_s3;
	logic [IDX_W-1:0] idx_s2, idx_s3;
	logic [PW-1:0] rd_s3;

	// last pipeline write, forwarded to the next read of the same cell
	logic             wr_vld_q;
	logic [IDX_W-1:0] wr_addr_q;
	logic [PW-1:0]    wr_data_q;

	// update datapath
	logic [PW-1:0] p0;
	logic [2:0]    sh;
	logic [PW:0]   p_inc, p_dec, p_new;
	logic [PW-1:0] p_upd;

	// configuration
	logic [MW-1:0] maxv_q;
	logic [bcpm_pkg::DEPTH_W-1:0] depth_sat;
	logic [MW-1:0] depth_lim;

	// output register
	logic          out_vld_q;
	logic          out_bit_q;
	logic [PW-1:0] out_prob_q;
	logic [IDX_W-1:0] out_idx_q;

	// table memory
	logic [PW-1:0] mem [TABLE_ENTRIES];
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [PW-1:0]    mem_wdata;

	always_comb begin
		in_plane = s_tdata[3:0];
		in_flags = s_tdata[12:4];
		for (int i = 0; i < bcpm_pkg::NBR; i++) begin
			in_vals[i] = s_tdata[13 + i*bcpm_pkg::VAL_W +: bcpm_pkg::VAL_W];
		end
		// coded bit comes from the raw centre value, present or not
		in_bit = in_vals[bcpm_pkg::NB_C][in_plane];
	end

	// the pipeline only holds when a finished result in s3 cannot reach the output register
	assign adv      = !(vld_s3 && (cmd_s3 == bcpm_pkg::CMD_CODE) && out_vld_q && !m_tready);
	assign s_tready = adv && !busy_q;
	assign s_accept = s_tvalid && s_tready;

	// ---------------------------------------------------------------- configuration
	assign cfg_ready = 1'b1;

	always_comb begin
		depth_sat = (cfg_data > bcpm_pkg::DEPTH_MAX) ? bcpm_pkg::DEPTH_MAX : cfg_data;
		depth_lim = (MW'(1) << depth_sat) - MW'(1);
	end

	// the register is kept as the prediction ceiling it implies
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxv_q <= MAXV_RST;
		end else if (cfg_valid && cfg_ready) begin
			maxv_q <= (depth_lim > TMAX) ? TMAX : depth_lim;
		end
	end

	// ---------------------------------------------------------------- stages 1 and 2
	bcpm_predict #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.IDX_W       (IDX_W)
	) u_predict (
		.clk       (clk),
		.en        (adv),
		.plane     (in_plane),
		.in_bounds (in_flags),
		.vals      (in_vals),
		.maxv      (maxv_q),
		.idx_s2    (idx_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1   <= s_tuser;
			bit_s1   <= in_bit;
			plane_s1 <= in_plane;
			cmd_s2   <= cmd_s1;
			bit_s2   <= bit_s1;
			plane_s2 <= plane_s1;
			cmd_s3   <= cmd_s2;
			bit_s3   <= bit_s2;
			plane_s3 <= plane_s2;
			idx_s3   <= idx_s2;
		end
	end

	// ---------------------------------------------------------------- table memory
	assign pipe_we = adv && vld_s3 && (cmd_s3 == bcpm_pkg::CMD_CODE);

	always_comb begin
		mem_we    = sweeping_q || pipe_we;
		mem_waddr = sweeping_q ? sweep_cnt_q : idx_s3;
		mem_wdata = sweeping_q ? bcpm_pkg::PROB_INIT : p_upd;
	end

	// read-first: a read of the cell being written returns the old value
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_s3 <= mem[idx_s2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (sweeping_q) begin
			wr_vld_q <= 1'b0;
		end else if (pipe_we) begin
			wr_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_we) begin
			wr_addr_q <= idx_s3;
			wr_data_q <= p_upd;
		end
	end

	// ---------------------------------------------------------------- clear sweep
	// busy from the clear transaction until its sweep has written the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			sweeping_q  <= 1'b1;
			sweep_cnt_q <= '0;
		end else if (sweeping_q) begin
			if (sweep_cnt_q == LAST_IDX) begin
				sweeping_q <= 1'b0;
				busy_q     <= 1'b0;
			end else begin
				sweep_cnt_q <= sweep_cnt_q + IDX_W'(1);
			end
		end else begin
			if (s_accept && (s_tuser == bcpm_pkg::CMD_CLEAR)) begin
				busy_q <= 1'b1;
			end
			if (adv && vld_s3 && (cmd_s3 == bcpm_pkg::CMD_CLEAR)) begin
				sweeping_q  <= 1'b1;
				sweep_cnt_q <= '0;
			end
		end
	end

	// ---------------------------------------------------------------- stage 3 update
	always_comb begin
		p0 = (wr_vld_q && (wr_addr_q == idx_s3)) ? wr_data_q : rd_s3;
		if (plane_s3 <= 4'd4) begin
			sh = 3'd7;
		end else if (plane_s3 == 4'd5) begin
			sh = 3'd6;
		end else begin
			sh = 3'd5;
		end
		// move toward zero-bit on a zero, away by a rounded-up step on a one
		p_inc = ((PW+1)'(1) << PW) - {1'b0, p0};
		p_inc = p_inc >> sh;
		p_dec = {1'b0, p0} + ((PW+1)'(1) << sh) - (PW+1)'(1);
		p_dec = p_dec >> sh;
		if (bit_s3) begin
			p_new = {1'b0, p0} - p_dec;
		end else begin
			p_new = {1'b0, p0} + p_inc;
		end
		if (p_new == '0) begin
			p_upd = PW'(1);
		end else if (p_new > {1'b0, bcpm_pkg::PROB_MAX}) begin
			p_upd = bcpm_pkg::PROB_MAX;
		end else begin
			p_upd = p_new[PW-1:0];
		end
	end

	// ---------------------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (pipe_we) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_we) begin
			out_bit_q  <= bit_s3;
			out_prob_q <= p0;
			out_idx_q  <= idx_s3;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, 16'(out_idx_q), out_prob_q, out_bit_q};

`ifndef NO_ASSERTIONS
	// no transaction is taken while the table is being swept
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping_q |-> !s_tready)
		else $error("input accepted during table sweep");

	// sweep and pipeline never compete for the write port
	a_write_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sweeping_q && pipe_we))
		else $error("pipeline write during table sweep");

	// the pipeline is empty while a sweep runs
	a_sweep_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(sweeping_q && $past(sweeping_q)) |-> !(vld_s1 || vld_s2 || vld_s3))
		else $error("items in flight during table sweep");

	// an updated cell never reaches zero
	a_prob_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pipe_we |-> (p_upd != '0))
		else $error("probability update reached zero");
`endif

endmodule

FILE: src/bcpm_predict.sv
// neighbour masking, gradient medians and clamped prediction, two register stages
module bcpm_predict #(
	parameter int SAMPLE_BITS = 16,
	parameter int IDX_W       = 16
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [3:0]                        plane,
	input  logic [bcpm_pkg::NBR-1:0]          in_bounds,
	input  bcpm_pkg::sample_arr_t             vals,
	input  logic [bcpm_pkg::MAXV_W-1:0]       maxv,
	output logic [IDX_W-1:0]                  idx_s2
);

	localparam int W = bcpm_pkg::VAL_W;
	localparam logic [W-1:0] SMASK = W'((17'(1) << SAMPLE_BITS) - 17'(1));

	logic [W-1:0] low_f, low_p, keep_p, keep_f;
	logic [bcpm_pkg::NBR-1:0][W-1:0] masked;
	logic [3:0][W-1:0] med_c;
	logic [3:0][W-1:0] med_s1;
	logic [W-1:0] c_s1;
	logic [W+1:0] med_sum;
	logic signed [W+4:0] acc;
	logic signed [W+2:0] pred;
	logic [bcpm_pkg::MAXV_W-1:0] pred_clamp;

	// median of a, b and the gradient a + b - x
	function automatic logic [W-1:0] med_grad(input logic [W-1:0] a, input logic [W-1:0] b,
			input logic [W-1:0] x);
		logic signed [W+1:0] g;
		logic [W-1:0] lo, hi;
		begin
			g  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, x});
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			if (g < $signed({2'b00, lo})) begin
				med_grad = lo;
			end else if (g > $signed({2'b00, hi})) begin
				med_grad = hi;
			end else begin
				med_grad = g[W-1:0];
			end
		end
	endfunction

	always_comb begin
		low_f  = W'((17'(1) << plane) - 17'(1));
		low_p  = low_f >> 1;
		keep_p = ~low_f;
		keep_f = ~{low_f[W-2:0], 1'b1};
	end

	// known planes: north row and west include the current plane, the rest do not
	always_comb begin
		for (int i = 0; i < bcpm_pkg::NBR; i++) begin
			if (i <= bcpm_pkg::NB_W) begin
				masked[i] = (in_bounds[i] ? (vals[i] & SMASK & keep_p) : '0) | low_p;
			end else begin
				masked[i] = (in_bounds[i] ? (vals[i] & SMASK & keep_f) : '0) | low_f;
			end
		end
	end

	always_comb begin
		med_c[0] = med_grad(masked[bcpm_pkg::NB_N], masked[bcpm_pkg::NB_W],
			masked[bcpm_pkg::NB_NW]);
		med_c[1] = med_grad(masked[bcpm_pkg::NB_S], masked[bcpm_pkg::NB_W],
			masked[bcpm_pkg::NB_SW]);
		med_c[2] = med_grad(masked[bcpm_pkg::NB_S], masked[bcpm_pkg::NB_E],
			masked[bcpm_pkg::NB_SE]);
		med_c[3] = med_grad(masked[bcpm_pkg::NB_N], masked[bcpm_pkg::NB_E],
			masked[bcpm_pkg::NB_NE]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			med_s1 <= med_c;
			c_s1   <= masked[bcpm_pkg::NB_C];
		end
	end

	// floor((8*c - sum) / 4) then clamp to 0 .. maxv
	always_comb begin
		med_sum = (W+2)'(med_s1[0]) + (W+2)'(med_s1[1]) + (W+2)'(med_s1[2])
			+ (W+2)'(med_s1[3]);
		acc  = $signed({2'b00, c_s1, 3'b000}) - $signed({3'b000, med_sum});
		pred = acc[W+4:2];
		if (pred < 0) begin
			pred_clamp = '0;
		end else if (pred[W+1:0] > {1'b0, maxv}) begin
			pred_clamp = maxv;
		end else begin
			pred_clamp = pred[bcpm_pkg::MAXV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2 <= pred_clamp[IDX_W-1:0];
		end
	end

endmodule

FILE: sim/bcpm_prob_checker.sv
`timescale 1ns / 1ps
// result checker for the bit-plane context model: predicts each code transaction and compares
module bcpm_prob_checker
	import bcpm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [39:0]  m_tdata,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [4:0]   cfg_data,
	output int           fail_count,
	output int           pending
);

	localparam int CELLS = 65536;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 5'd8;

	// same bit order as m_tdata
	typedef struct packed {
		logic [VAL_W-1:0]  ctx;
		logic [PROB_W-1:0] prob;
		logic              coded_bit;
	} coded_res_t;

	logic [PROB_W-1:0]  prob_cells [CELLS];
	logic [DEPTH_W-1:0] depth_reg;
	coded_res_t         coded_q [$];
	int                 errs;

	function automatic int masked_sample(logic [VAL_W-1:0] v, logic present,
			logic [31:0] keep, logic [31:0] fill);
		logic [31:0] x;
		x = present ? ({16'd0, v} & keep) : 32'd0;
		return int'((x | fill) & 32'h1FFFF);
	endfunction

	function automatic int median3(int a, int b, int c);
		int lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c < lo) return lo;
		if (c > hi) return hi;
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [3:0]     kb;
		logic [NBR-1:0] flags;
		sample_arr_t    smp;
		logic [31:0]    lowf, lowp, keepp, keepf;
		int             nb [NBR];
		int             pnw, psw, pse, pne, acc, pred, maxv, eff_depth, sh, p0, p, i;
		coded_res_t     want, got;
		if (!arst_n) begin
			for (i = 0; i < CELLS; i++) prob_cells[i] = PROB_INIT;
			depth_reg = DEPTH_RESET;
			coded_q.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) depth_reg = cfg_data;

			if (m_tvalid && m_tready) begin
				got = m_tdata[32:0];
				if (coded_q.size() == 0) begin
					$error("result with no expectation: m_tdata %h", m_tdata);
					errs++;
				end else begin
					want = coded_q.pop_front();
					if (got.coded_bit !== want.coded_bit) begin
						$error("coded_bit mismatch: expected %0d, actual %0d",
							want.coded_bit, got.coded_bit);
						errs++;
					end
					if (got.prob !== want.prob) begin
						$error("prob_zero mismatch: expected %h, actual %h", want.prob, got.prob);
						errs++;
					end
					if (got.ctx !== want.ctx) begin
						$error("context_res mismatch: expected %h, actual %h", want.ctx, got.ctx);
						errs++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_CLEAR) begin
					for (i = 0; i < CELLS; i++) prob_cells[i] = PROB_INIT;
				end else begin
					kb    = s_tdata[3:0];
					flags = s_tdata[12:4];
					smp   = s_tdata[156:13];
					lowf  = (32'd1 << kb) - 32'd1;
					lowp  = lowf >> 1;
					keepp = ~lowf;
					keepf = ~((32'd2 << kb) - 32'd1);
					// north side and west keep the current plane, the rest only higher planes
					for (i = 0; i < NBR; i++)
						nb[i] = masked_sample(smp[i], flags[i], (i < NB_C) ? keepp : keepf,
							(i < NB_C) ? lowp : lowf);
					pnw = median3(nb[NB_N], nb[NB_W], nb[NB_N] + nb[NB_W] - nb[NB_NW]);
					psw = median3(nb[NB_S], nb[NB_W], nb[NB_S] + nb[NB_W] - nb[NB_SW]);
					pse = median3(nb[NB_S], nb[NB_E], nb[NB_S] + nb[NB_E] - nb[NB_SE]);
					pne = median3(nb[NB_N], nb[NB_E], nb[NB_N] + nb[NB_E] - nb[NB_NE]);
					acc = 8 * nb[NB_C] - (pnw + psw + pse + pne);
					pred = acc >>> 2;
					eff_depth = (depth_reg > DEPTH_MAX) ? int'(DEPTH_MAX) : int'(depth_reg);
					maxv = (1 << eff_depth) - 1;
					if (maxv > CELLS - 1) maxv = CELLS - 1;
					if (pred < 0) pred = 0;
					if (pred > maxv) pred = maxv;

					p0 = int'(prob_cells[pred]);
					want.coded_bit = smp[NB_C][kb];
					want.prob = p0[PROB_W-1:0];
					want.ctx = pred[VAL_W-1:0];
					sh = (kb <= 4'd4) ? 7 : ((kb == 4'd5) ? 6 : 5);
					if (!want.coded_bit) p = p0 + ((65536 - p0) >> sh);
					else p = p0 - ((p0 + (1 << sh) - 1) >> sh);
					if (p < 1) p = 1;
					if (p > int'(PROB_MAX)) p = int'(PROB_MAX);
					prob_cells[pred] = p[PROB_W-1:0];
					coded_q.push_back(want);
				end
			end

			fail_count <= errs;
			pending <= coded_q.size();
		end
	end

endmodule

FILE: sim/bitplane_context_probability_model_top_tb.sv
`timescale 1ns / 1ps
// testbench top for the bit-plane context probability model: stimulus, idling and verdict
module bitplane_context_probability_model_top_tb;
	import bcpm_pkg::*;

	// longest quiet stretch of a correct run is one table sweep
	localparam int WATCHDOG_LIMIT = 200000;
	// results trail the input transactions through the pipeline; leave margin
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 20;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [159:0] s_tdata   = '0;
	logic         s_tuser   = 1'b0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [39:0]  m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [4:0]   cfg_data  = '0;

	int chk_fails;
	int chk_pending;
	// percent chance of an idle burst before each transaction, shared by both sides
	int idle_pct    = 0;
	// table sweeps are long, so random clears are rationed
	int clears_left = 4;

	always #5 clk = ~clk;

	bitplane_context_probability_model_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bcpm_prob_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (chk_fails),
		.pending    (chk_pending)
	);

	function automatic sample_arr_t random_samples();
		sample_arr_t r;
		for (int i = 0; i < NBR; i++) r[i] = 16'($urandom);
		return r;
	endfunction

	// one input transaction; valid stays high from one transaction to the next unless idling
	task automatic send_txn(logic cmd, logic [3:0] kb, logic [NBR-1:0] flags, sample_arr_t smp);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		// zero fill, samples se..nw, in_bounds, plane
		s_tdata  <= {3'b000, smp, flags, kb};
		do @(posedge clk); while (!s_tready);
	endtask

	// hold the input off until every result is out, then let the pipeline settle
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (chk_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// channel_depth changes only while the block is idle
	task automatic write_depth(logic [DEPTH_W-1:0] d);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// force_bit >= 0 pins the centre bit at the plane, to drive a cell toward a bound
	task automatic random_phase(int count, int force_bit, int kb_lo);
		logic [3:0]     kb;
		logic [NBR-1:0] flags;
		sample_arr_t    smp;
		int             base, mode;
		for (int n = 0; n < count; n++) begin
			if (force_bit < 0 && clears_left > 0 && $urandom_range(0, 299) == 0) begin
				clears_left--;
				send_txn(CMD_CLEAR, 4'($urandom), 9'($urandom), random_samples());
			end
			kb    = 4'($urandom_range(kb_lo, 15));
			// mostly a full neighbourhood, sometimes image borders
			flags = ($urandom_range(0, 3) == 0) ? 9'($urandom) : '1;
			mode  = $urandom_range(0, 2);
			base  = $urandom_range(0, 65535) >> $urandom_range(0, 16);
			case (mode)
				0: smp = random_samples();
				// smooth patch: prediction lands near the centre value
				1: for (int i = 0; i < NBR; i++) smp[i] = 16'(base + $urandom_range(0, 15));
				// tiny values: many hits on a few low cells
				default: for (int i = 0; i < NBR; i++) smp[i] = 16'($urandom_range(0, 31));
			endcase
			if (force_bit >= 0) smp[NB_C][kb] = force_bit[0];
			send_txn(CMD_CODE, kb, flags, smp);
		end
	endtask

	// receiver: ready in random stretches, broken by idle bursts when enabled
	initial begin : result_sink
		@(posedge clk);
		forever begin
			if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	// watchdog: any accepted transaction on any channel restarts the count
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
					(cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL bitplane_context_probability_model_top");
		$finish;
	end

	initial begin : stimulus
		sample_arr_t smp;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset depth of eight
		idle_pct = 15;
		// all zero and all ones, lowest and highest plane
		send_txn(CMD_CODE, 4'd0, '1, '0);
		send_txn(CMD_CODE, 4'd15, '1, '1);
		// every neighbour out of bounds
		send_txn(CMD_CODE, 4'd0, '0, '1);
		// centre flagged absent, coded bit still from its value
		for (int i = 0; i < NBR; i++) smp[i] = 16'h1234;
		smp[NB_C] = 16'hFFFF;
		send_txn(CMD_CODE, 4'd3, 9'h1EF, smp);
		// steep gradients with a dark centre: prediction below zero
		smp = '0;
		smp[NB_N] = 16'hFFFF;
		smp[NB_W] = 16'hFFFF;
		smp[NB_S] = 16'hFFFF;
		smp[NB_E] = 16'hFFFF;
		send_txn(CMD_CODE, 4'd0, '1, smp);
		// bright centre on dark ground: prediction above the depth limit
		smp = '0;
		smp[NB_C] = 16'hFFFF;
		send_txn(CMD_CODE, 4'd0, '1, smp);
		// planes around the adaptation shift steps
		send_txn(CMD_CODE, 4'd4, '1, random_samples());
		send_txn(CMD_CODE, 4'd5, '1, random_samples());
		send_txn(CMD_CODE, 4'd6, '1, random_samples());
		// successive hits on one cell, one bits then zero bits
		for (int i = 0; i < NBR; i++) smp[i] = 16'h00A0;
		send_txn(CMD_CODE, 4'd5, '1, smp);
		send_txn(CMD_CODE, 4'd5, '1, smp);
		smp[NB_C] = 16'h0080;
		send_txn(CMD_CODE, 4'd5, '1, smp);
		send_txn(CMD_CODE, 4'd5, '1, smp);
		// plane at or above the channel depth
		send_txn(CMD_CODE, 4'd12, '1, random_samples());
		send_txn(CMD_CODE, 4'd8, '1, random_samples());
		// clear, then revisit the first cell, which must read one half again
		send_txn(CMD_CLEAR, 4'd0, '0, '0);
		send_txn(CMD_CODE, 4'd0, '1, '0);
		send_txn(CMD_CODE, 4'd0, '1, '0);

		// random phases over several depths, extremes included
		write_depth(5'd16);
		idle_pct = 30;
		random_phase(200, -1, 0);

		// depth zero: everything maps to cell zero; drive it to the floor, then back up
		write_depth(5'd0);
		idle_pct = 20;
		random_phase(300, 1, 6);
		random_phase(150, 0, 0);

		// depth above sixteen saturates
		write_depth(5'd31);
		idle_pct = 40;
		random_phase(200, -1, 0);

		write_depth(5'd1);
		idle_pct = 10;
		random_phase(150, -1, 0);

		write_depth(5'd5);
		idle_pct = 50;
		random_phase(150, -1, 0);

		write_depth(5'($urandom));
		idle_pct = 25;
		random_phase(150, -1, 0);

		write_depth(5'd12);
		idle_pct = 30;
		random_phase(100, -1, 0);

		// closing stretch at full rate on both sides
		write_depth(5'd8);
		idle_pct = 0;
		random_phase(150, -1, 0);

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (chk_fails == 0 && chk_pending == 0)
			$display("PASS bitplane_context_probability_model_top");
		else
			$display("FAIL bitplane_context_probability_model_top");
		$finish;
	end

endmodule

FILE: filelist.f
src/bcpm_pkg.sv
src/bcpm_predict.sv
src/bitplane_context_probability_model_top.sv
sim/bcpm_prob_checker.sv
sim/bitplane_context_probability_model_top_tb.sv
